FILE: src/ctd_pkg.sv
// Shared types, class codes and the fixed token class table for the detokenizer.
`timescale 1ns / 1ps

package ctd_pkg;

	// Depth limit for block nesting; the 6-bit counter caps it at 63
	localparam int MAX_DEPTH = 63;
	localparam logic [5:0] DEPTH_CAP = 6'((MAX_DEPTH < 63) ? MAX_DEPTH : 63);

	localparam int NAME_W   = 15;
	localparam int DEPTH_W  = 6;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_TUSER_W = 4;

	typedef logic [3:0] cls_t;

	// Token classes
	localparam cls_t CX = 4'd0; // no token
	localparam cls_t CK = 4'd1; // keyword
	localparam cls_t CH = 4'd2; // head keyword
	localparam cls_t CE = 4'd3; // end keyword
	localparam cls_t CA = 4'd4; // arithmetic
	localparam cls_t CR = 4'd5; // relational
	localparam cls_t CL = 4'd6; // logical
	localparam cls_t CS = 4'd7; // special
	localparam cls_t CN = 4'd8; // line break

	// Output groups
	localparam logic [2:0] GRP_KEYWORD = 3'd0;
	localparam logic [2:0] GRP_ARITH   = 3'd1;
	localparam logic [2:0] GRP_REL     = 3'd2;
	localparam logic [2:0] GRP_LOGIC   = 3'd3;
	localparam logic [2:0] GRP_SPECIAL = 3'd4;
	localparam logic [2:0] GRP_USER    = 3'd5;
	localparam logic [2:0] GRP_BREAK   = 3'd6;

	// Class of each single-byte code
	localparam cls_t CLASS_ROM [0:127] = '{
		CX, CH, CH, CH, CH, CH, CH, CH,
		CE, CH, CH, CK, CK, CH, CX, CK,
		CK, CX, CX, CX, CH, CK, CH, CH,
		CX, CH, CX, CX, CH, CX, CH, CH,
		CH, CH, CX, CX, CX, CX, CX, CX,
		CX, CE, CK, CK, CK, CK, CS, CS,
		CX, CX, CS, CS, CS, CS, CS, CS,
		CS, CS, CX, CX, CA, CA, CL, CS,
		CX, CX, CS, CX, CX, CX, CA, CA,
		CA, CA, CA, CA, CS, CX, CX, CX,
		CS, CA, CA, CA, CA, CL, CL, CL,
		CL, CR, CR, CR, CR, CR, CR, CS,
		CX, CX, CX, CX, CN, CN, CN, CN,
		CX, CX, CX, CX, CX, CX, CX, CX,
		CX, CX, CX, CX, CX, CX, CX, CX,
		CX, CX, CX, CX, CX, CX, CX, CX
	};

	function automatic logic [2:0] group_of(input cls_t cls);
		logic [2:0] grp;
		case (cls)
			CA:      grp = GRP_ARITH;
			CR:      grp = GRP_REL;
			CL:      grp = GRP_LOGIC;
			CS:      grp = GRP_SPECIAL;
			CN:      grp = GRP_BREAK;
			default: grp = GRP_KEYWORD;
		endcase
		return grp;
	endfunction

	// Decoder state carried from byte to byte
	typedef struct packed {
		logic [DEPTH_W-1:0] nest_depth;
		logic               prev_kw;
		logic               prev_lb;
		logic [6:0]         pend_hi;
		logic               pend_v;
		logic               stopped;
	} ctd_state_t;

	// One result word
	typedef struct packed {
		logic [NAME_W-1:0]  token_id;
		logic               is_user_name;
		logic [2:0]         token_group;
		logic               space_before;
		logic [DEPTH_W-1:0] indent_before;
		logic               error_flag;
	} ctd_result_t;

endpackage

FILE: src/ctd_decode.sv
// Per-byte decode: class lookup, name id check, depth and indent update.
`timescale 1ns / 1ps

module ctd_decode (
	input  logic [7:0]                  code_byte,
	input  logic                        end_of_code,
	input  logic [ctd_pkg::NAME_W-1:0]  name_count,
	input  ctd_pkg::ctd_state_t         cur,
	output ctd_pkg::ctd_state_t         nxt,
	output logic                        has_result,
	output ctd_pkg::ctd_result_t        res
);

	ctd_pkg::cls_t              cls;
	logic [ctd_pkg::NAME_W-1:0] raw;
	logic [ctd_pkg::NAME_W-1:0] id;
	logic                       raw_low;
	logic [ctd_pkg::DEPTH_W-1:0] depth_dec;

	always_comb begin
		cls     = ctd_pkg::CLASS_ROM[code_byte[6:0]];
		raw     = {cur.pend_hi, code_byte};
		raw_low = (cur.pend_hi == 7'd0) && !code_byte[7];
		id      = raw - ctd_pkg::NAME_W'(128);
		// end keyword closes a block before its own indent is taken
		depth_dec = (cls == ctd_pkg::CE && cur.nest_depth != '0) ?
			cur.nest_depth - 1'b1 : cur.nest_depth;

		nxt        = cur;
		has_result = 1'b0;
		res        = '0;

		if (cur.stopped) begin
			// sticky error: swallow everything
			has_result = 1'b0;
		end else if (cur.pend_v) begin
			// low byte of a user name reference
			nxt.pend_v  = 1'b0;
			nxt.pend_hi = '0;
			has_result  = 1'b1;
			if (raw_low || id >= name_count) begin
				nxt.stopped    = 1'b1;
				res.error_flag = 1'b1;
			end else begin
				res.token_id     = id;
				res.is_user_name = 1'b1;
				res.token_group  = ctd_pkg::GRP_USER;
				res.space_before = cur.prev_kw;
				res.indent_before = (!cur.prev_kw && cur.prev_lb) ? cur.nest_depth : '0;
				nxt.prev_kw = 1'b0;
				nxt.prev_lb = 1'b0;
			end
		end else if (code_byte[7]) begin
			// high byte of a user name reference
			if (end_of_code) begin
				nxt.stopped    = 1'b1;
				has_result     = 1'b1;
				res.error_flag = 1'b1;
			end else begin
				nxt.pend_hi = code_byte[6:0];
				nxt.pend_v  = 1'b1;
			end
		end else begin
			// fixed token
			has_result = 1'b1;
			if (cls == ctd_pkg::CX) begin
				nxt.stopped    = 1'b1;
				res.error_flag = 1'b1;
			end else begin
				res.token_id      = ctd_pkg::NAME_W'(code_byte);
				res.token_group   = ctd_pkg::group_of(cls);
				res.indent_before = (cur.prev_lb && cls != ctd_pkg::CN) ? depth_dec : '0;
				nxt.prev_kw = (cls == ctd_pkg::CK) || (cls == ctd_pkg::CH) ||
					(cls == ctd_pkg::CE);
				nxt.prev_lb = (cls == ctd_pkg::CN);
				nxt.nest_depth = (cls == ctd_pkg::CH && depth_dec < ctd_pkg::DEPTH_CAP) ?
					depth_dec + 1'b1 : depth_dec;
			end
		end
	end

endmodule

FILE: src/code_token_detokenizer.sv
// Top level: input register, decode stage, output register and config register.
// Each input word is registered, then its result word is registered for the master side.
// Throughput: one input word per cycle while results are taken; the decode between the
// input and result registers is one class lookup plus a 15-bit subtract and compare.
// A first byte of a name reference produces no result word, unless it ends the code: then an error word.
// Reset (arst_n low, asynchronous): all decode state, name_count and valid flags clear.
`timescale 1ns / 1ps

module code_token_detokenizer (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave side: tdata = code_byte[7:0]; tlast = end_of_code
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ctd_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic                              s_tlast,
	// master side: tdata = token_id[14:0], space_before[15], indent_before[21:16],
	// error_flag[22], zero[23]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ctd_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// tuser = is_user_name[0], token_group[3:1]
	output logic [ctd_pkg::OUT_TUSER_W-1:0]   m_tuser,
	// config write: name_count
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ctd_pkg::NAME_W-1:0]        cfg_data
);

	logic                       valid_s1;
	logic [7:0]                 byte_s1;
	logic                       last_s1;
	logic                       out_valid_q;
	ctd_pkg::ctd_result_t       out_q;
	ctd_pkg::ctd_state_t        state_q;
	ctd_pkg::ctd_state_t        state_nxt;
	logic [ctd_pkg::NAME_W-1:0] name_count_q;
	logic                       has_result;
	ctd_pkg::ctd_result_t       res;
	logic                       advance;

	ctd_decode u_decode (
		.code_byte   (byte_s1),
		.end_of_code (last_s1),
		.name_count  (name_count_q),
		.cur         (state_q),
		.nxt         (state_nxt),
		.has_result  (has_result),
		.res         (res)
	);

	// stage 1 moves on when the result slot is free or the word needs none
	assign advance  = valid_s1 && (!out_valid_q || m_tready || !has_result);
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_count_q <= '0;
		end else if (cfg_valid) begin
			name_count_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[7:0];
			last_s1 <= s_tlast;
		end
	end

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.error_flag, out_q.indent_before, out_q.space_before,
		out_q.token_id};
	assign m_tuser  = {out_q.token_group, out_q.is_user_name};

	// an error word carries nothing else
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[22]) |-> (m_tdata[21:0] == '0 && m_tuser == '0))
		else $error("error word carries nonzero fields");

	// once stopped, the decoder stays stopped
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.stopped |=> state_q.stopped)
		else $error("error state cleared without reset");

	// user name results always report the user name group
	a_user_grp: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tuser[3:1] == ctd_pkg::GRP_USER))
		else $error("user name with wrong group");

	// nesting depth never passes its cap
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.nest_depth <= ctd_pkg::DEPTH_CAP)
		else $error("nest depth above cap");

endmodule

FILE: test/code_token_detokenizer_test.sv
// Self-checking stream testbench for the code token detokenizer.
`timescale 1ns / 1ps

module code_token_detokenizer_test;

	localparam int CYCLE_LIMIT = 300000;
	localparam int MAX_REPORTS = 100;

	typedef struct {
		logic [7:0] code;
		logic       last;
	} code_word_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [ctd_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic                            s_tlast = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [ctd_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic [ctd_pkg::OUT_TUSER_W-1:0] m_tuser;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [ctd_pkg::NAME_W-1:0]      cfg_data = '0;

	// bytes waiting to be sent, and decoded tokens waiting on the master side
	code_word_t           code_bytes[$];
	ctd_pkg::ctd_result_t decoded_tokens[$];
	int                   bytes_queued = 0;
	int                   mismatches = 0;
	int                   cycles = 0;
	int                   send_idle_pct = 26;
	int                   take_idle_pct = 26;

	// decoder state as the block should hold it
	logic [ctd_pkg::NAME_W-1:0]  names_limit = '0;
	logic [ctd_pkg::DEPTH_W-1:0] depth = '0;
	logic                        after_keyword = 1'b0;
	logic                        after_break = 1'b0;
	logic [6:0]                  high_part = '0;
	logic                        high_pending = 1'b0;
	logic                        halted = 1'b0;

	code_token_detokenizer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// class of a single-byte code
	function automatic ctd_pkg::cls_t code_class(input logic [6:0] c);
		case (c)
			7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd9, 7'd10, 7'd13, 7'd20, 7'd22,
			7'd23, 7'd25, 7'd28, 7'd30, 7'd31, 7'd32, 7'd33:
				return ctd_pkg::CH;
			7'd8, 7'd41:
				return ctd_pkg::CE;
			7'd11, 7'd12, 7'd15, 7'd16, 7'd21, 7'd42, 7'd43, 7'd44, 7'd45:
				return ctd_pkg::CK;
			7'd46, 7'd47, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57, 7'd63,
			7'd66, 7'd76, 7'd80, 7'd95:
				return ctd_pkg::CS;
			7'd60, 7'd61, 7'd70, 7'd71, 7'd72, 7'd73, 7'd74, 7'd75, 7'd81, 7'd82, 7'd83,
			7'd84:
				return ctd_pkg::CA;
			7'd62, 7'd85, 7'd86, 7'd87, 7'd88:
				return ctd_pkg::CL;
			7'd89, 7'd90, 7'd91, 7'd92, 7'd93, 7'd94:
				return ctd_pkg::CR;
			7'd100, 7'd101, 7'd102, 7'd103:
				return ctd_pkg::CN;
			default:
				return ctd_pkg::CX;
		endcase
	endfunction

	// sticky error: one error word, then silence
	function automatic void halt_on_error();
		ctd_pkg::ctd_result_t r;
		r = '0;
		r.error_flag = 1'b1;
		halted = 1'b1;
		high_pending = 1'b0;
		high_part = '0;
		decoded_tokens.push_back(r);
	endfunction

	// decode one accepted byte and queue the token it yields, if any
	function automatic void detokenize(input logic [7:0] b, input logic last);
		ctd_pkg::ctd_result_t r;
		ctd_pkg::cls_t        c;
		logic [15:0]          raw;
		if (halted)
			return;
		r = '0;
		// second byte of a name reference
		if (high_pending) begin
			raw = {1'b0, high_part, b};
			high_pending = 1'b0;
			high_part = '0;
			if (raw < 16'd128 || (raw - 16'd128) >= {1'b0, names_limit}) begin
				halt_on_error();
				return;
			end
			r.token_id = 15'(raw - 16'd128);
			r.is_user_name = 1'b1;
			r.token_group = ctd_pkg::GRP_USER;
			if (after_keyword)
				r.space_before = 1'b1;
			else if (after_break)
				r.indent_before = depth;
			after_keyword = 1'b0;
			after_break = 1'b0;
			decoded_tokens.push_back(r);
			return;
		end
		// first byte of a name reference
		if (b[7]) begin
			if (last)
				halt_on_error();
			else begin
				high_part = b[6:0];
				high_pending = 1'b1;
			end
			return;
		end
		// fixed token
		c = code_class(b[6:0]);
		if (c == ctd_pkg::CX) begin
			halt_on_error();
			return;
		end
		if (c == ctd_pkg::CE && depth != 0)
			depth = depth - 1'b1;
		if (after_break && c != ctd_pkg::CN)
			r.indent_before = depth;
		after_keyword = (c == ctd_pkg::CK || c == ctd_pkg::CH || c == ctd_pkg::CE);
		after_break = (c == ctd_pkg::CN);
		if (c == ctd_pkg::CH && depth < ctd_pkg::DEPTH_CAP)
			depth = depth + 1'b1;
		r.token_id = {7'd0, b};
		case (c)
			ctd_pkg::CA: r.token_group = ctd_pkg::GRP_ARITH;
			ctd_pkg::CR: r.token_group = ctd_pkg::GRP_REL;
			ctd_pkg::CL: r.token_group = ctd_pkg::GRP_LOGIC;
			ctd_pkg::CS: r.token_group = ctd_pkg::GRP_SPECIAL;
			ctd_pkg::CN: r.token_group = ctd_pkg::GRP_BREAK;
			default:     r.token_group = ctd_pkg::GRP_KEYWORD;
		endcase
		decoded_tokens.push_back(r);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < MAX_REPORTS)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic check_token(input logic [ctd_pkg::OUT_TDATA_W-1:0] d,
		input logic [ctd_pkg::OUT_TUSER_W-1:0] u);
		ctd_pkg::ctd_result_t want;
		if (decoded_tokens.size() == 0) begin
			report_mismatch("unexpected result word", int'(d), 0);
			return;
		end
		want = decoded_tokens.pop_front();
		if (d[14:0] !== want.token_id)
			report_mismatch("token_id", d[14:0], want.token_id);
		if (d[15] !== want.space_before)
			report_mismatch("space_before", d[15], want.space_before);
		if (d[21:16] !== want.indent_before)
			report_mismatch("indent_before", d[21:16], want.indent_before);
		if (d[22] !== want.error_flag)
			report_mismatch("error_flag", d[22], want.error_flag);
		if (d[23] !== 1'b0)
			report_mismatch("tdata pad bit", d[23], 0);
		if (u[0] !== want.is_user_name)
			report_mismatch("is_user_name", u[0], want.is_user_name);
		if (u[3:1] !== want.token_group)
			report_mismatch("token_group", u[3:1], want.token_group);
	endtask

	// slave side: send queued bytes, predict on every accepted word
	always @(posedge clk) begin : drive_codes
		code_word_t w;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				detokenize(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (code_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					w = code_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= w.code;
					s_tlast <= w.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// master side: random back-pressure, check every accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_token(m_tdata, m_tuser);
			m_tready <= ($urandom_range(0, 99) >= take_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("code_token_detokenizer_test failed");
			$finish;
		end
	end

	task automatic push_word(input logic [7:0] code, input logic last);
		code_word_t w;
		w.code = code;
		w.last = last;
		code_bytes.push_back(w);
		bytes_queued++;
	endtask

	task automatic push_name(input int id, input logic last);
		logic [15:0] raw;
		raw = 16'(id) + 16'd128;
		push_word({1'b1, raw[14:8]}, 1'b0);
		push_word(raw[7:0], last);
	endtask

	// random byte of the given class
	task automatic push_fixed(input ctd_pkg::cls_t c);
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 127));
		while (code_class(b[6:0]) != c);
		push_word(b, $urandom_range(0, 15) == 0);
	endtask

	// largest name id that fits the table and two bytes
	function automatic int top_name_id();
		return (names_limit < 15'd32640) ? int'(names_limit) - 1 : 32639;
	endfunction

	task automatic push_token();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 30 && names_limit != 0)
			push_name($urandom_range(0, top_name_id()), $urandom_range(0, 15) == 0);
		else if (sel < 45)
			push_fixed(ctd_pkg::CH);
		else if (sel < 60)
			push_fixed(ctd_pkg::CE);
		else begin
			case ($urandom_range(0, 5))
				0: push_fixed(ctd_pkg::CK);
				1: push_fixed(ctd_pkg::CA);
				2: push_fixed(ctd_pkg::CR);
				3: push_fixed(ctd_pkg::CL);
				4: push_fixed(ctd_pkg::CS);
				default: push_fixed(ctd_pkg::CN);
			endcase
		end
	endtask

	// lines of random tokens, now and then a nesting run past the depth limit
	task automatic push_lines(input int count);
		int start;
		int sel;
		start = bytes_queued;
		if (names_limit != 0) begin
			push_name(0, 1'b0);
			push_name(top_name_id(), 1'b0);
		end
		while (bytes_queued - start < count) begin
			sel = $urandom_range(0, 199);
			if (sel == 0) begin
				repeat ($urandom_range(64, 80)) begin
					push_fixed(ctd_pkg::CH);
					push_fixed(ctd_pkg::CN);
				end
			end else if (sel == 1) begin
				repeat ($urandom_range(64, 80)) begin
					push_fixed(ctd_pkg::CE);
					push_fixed(ctd_pkg::CN);
				end
			end else begin
				repeat ($urandom_range(1, 6))
					push_token();
				push_fixed(ctd_pkg::CN);
			end
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (code_bytes.size() != 0 || s_tvalid || decoded_tokens.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_name_count(input logic [ctd_pkg::NAME_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		names_limit = value;
	endtask

	initial begin
		int id;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every class, depth floor, name id extremes, tlast on full tokens
		write_name_count(15'd32767);
		push_word(8'h08, 1'b0);  // end keyword at depth zero
		push_word(8'h01, 1'b0);  // head keyword
		push_word(8'h0B, 1'b0);  // keyword, then a name gets a space
		push_word(8'h80, 1'b0);  // name id 0 from high part zero
		push_word(8'h80, 1'b0);
		push_word(8'h64, 1'b0);  // line break, then an indented name
		push_word(8'hFF, 1'b0);  // highest id two bytes can carry
		push_word(8'hFF, 1'b0);
		push_word(8'h3C, 1'b0);
		push_word(8'h59, 1'b0);
		push_word(8'h3E, 1'b0);
		push_word(8'h2E, 1'b0);
		push_word(8'h67, 1'b0);
		push_word(8'h1F, 1'b0);  // indented head keyword
		push_word(8'h29, 1'b0);  // end keyword
		push_name(128, 1'b1);    // low byte zero, end of stream
		push_word(8'h5F, 1'b1);
		push_lines(300);
		wait_drained();

		write_name_count(15'($urandom_range(1, 32767)));
		push_lines(350);
		wait_drained();

		// no names at all, and no idling on either side
		write_name_count(15'd0);
		send_idle_pct = 0;
		take_idle_pct = 0;
		push_lines(300);
		wait_drained();
		send_idle_pct = 26;
		take_idle_pct = 26;

		write_name_count(15'($urandom_range(1, 64)));
		push_lines(350);
		wait_drained();

		// last phase ends in an error, since errors stick until reset
		write_name_count(15'($urandom_range(1, 20000)));
		push_lines(350);
		case ($urandom_range(0, 3))
			0: begin  // id below zero
				push_word(8'h80, 1'b0);
				push_word(8'($urandom_range(0, 127)), 1'b0);
			end
			1: begin  // id at or above the name count
				if ($urandom_range(0, 1))
					id = int'(names_limit);
				else
					id = $urandom_range(int'(names_limit), 32639);
				push_name(id, 1'b0);
			end
			2:
				push_fixed(ctd_pkg::CX);
			default:  // stream ends on the first byte of a name
				push_word({1'b1, 7'($urandom)}, 1'b1);
		endcase
		// ignored after the error
		repeat (8)
			push_word(8'($urandom), 1'($urandom));
		wait_drained();
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("code_token_detokenizer_test passed");
		else
			$display("code_token_detokenizer_test failed");
		$finish;
	end

endmodule
